>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the adam update block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ADAM_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// same-cycle implication
`define ADAM_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ADAM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/adam_pkg.sv
// ----------------------------------------------------------------------------
// adam_pkg
// shared constants and types of the adam parameter update block
// ----------------------------------------------------------------------------
`default_nettype none

package adam_pkg;

  localparam int DATA_WIDTH = 48;
  localparam int FRAC_BITS  = 24;
  localparam int QB         = 24;
  localparam int BETA_W     = 24;
  localparam int STEP_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [BETA_W-1:0] BETA_FIRST_RST    = 24'd15099494;
  localparam logic [BETA_W-1:0] BETA_SECOND_RST   = 24'd16760439;
  localparam logic [BETA_W-1:0] EPSILON_RST       = 24'd1;
  localparam logic [BETA_W-1:0] LEARNING_RATE_RST = 24'd503316;
  localparam logic [STEP_W-1:0] STEP_COUNT_RST    = 17'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA_FIRST    = 3'd0,
    CFG_BETA_SECOND   = 3'd1,
    CFG_EPSILON       = 3'd2,
    CFG_LEARNING_RATE = 3'd3,
    CFG_STEP_COUNT    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [BETA_W-1:0] beta_first;
    logic [BETA_W-1:0] beta_second;
    logic [STEP_W-1:0] step_count;
    logic              start;
  } bias_req_t;

endpackage

`default_nettype wire

>>> hdl/adam_if.sv
// ----------------------------------------------------------------------------
// adam channel interfaces
// element, result and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface adam_elem_if #(parameter int DATA_WIDTH = adam_pkg::DATA_WIDTH) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] gradient;
  logic signed [DATA_WIDTH-1:0] moment1_old;
  logic        [DATA_WIDTH-2:0] moment2_old;
  logic signed [DATA_WIDTH-1:0] param_old;
  logic                         last_in;
  modport source (output valid, gradient, moment1_old, moment2_old, param_old, last_in,
                  input ready);
  modport sink (input valid, gradient, moment1_old, moment2_old, param_old, last_in,
                output ready);
endinterface

interface adam_result_if #(parameter int DATA_WIDTH = adam_pkg::DATA_WIDTH) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] moment1_new;
  logic        [DATA_WIDTH-2:0] moment2_new;
  logic signed [DATA_WIDTH-1:0] param_new;
  logic                         last_out;
  logic                         saturated;
  modport source (output valid, moment1_new, moment2_new, param_new, last_out, saturated,
                  input ready);
  modport sink (input valid, moment1_new, moment2_new, param_new, last_out, saturated,
                output ready);
endinterface

interface adam_cfg_if ();
  logic                               valid;
  logic                               ready;
  logic [adam_pkg::CFG_IDX_W-1:0]     index;
  logic [adam_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/adam_mul.sv
// ----------------------------------------------------------------------------
// adam_mul
// two-stage unsigned multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
`default_nettype none

module adam_mul #(
  parameter int AW = 48,
  parameter int BW = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pll;
  logic [AL+BH-1:0] plh;
  logic [AH+BL-1:0] phl;
  logic [AH+BH-1:0] phh;

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
      plh <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
      phl <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
      phh <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
      p   <= (PW'(phh) << (AL+BL)) + (PW'(phl) << AL) + (PW'(plh) << BL) + PW'(pll);
    end
  end

endmodule

`default_nettype wire

>>> hdl/adam_bias.sv
// ----------------------------------------------------------------------------
// adam_bias
// sequencer for the bias correction reciprocals 1/(1-beta^step)
// ----------------------------------------------------------------------------
`default_nettype none

module adam_bias #(
  parameter int DATA_WIDTH = adam_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = adam_pkg::FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  adam_pkg::bias_req_t     req,
  output logic [DATA_WIDTH-1:0]   bias1_recip,
  output logic [DATA_WIDTH-1:0]   bias2_recip,
  output logic                    busy
);

  localparam int QB  = adam_pkg::QB;
  localparam int SW  = adam_pkg::STEP_W;
  localparam int NB  = QB + FRAC_BITS + 1;
  localparam int CW  = $clog2(NB);
  localparam int MW  = (NB > DATA_WIDTH) ? NB : DATA_WIDTH;
  localparam logic [QB:0] ONE = (QB+1)'(1) << QB;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_POWER, S_SETUP, S_DIVIDE, S_FINISH} state_t;

  state_t          state;
  logic            sel;
  logic [CW-1:0]   cnt;
  logic [QB:0]     pw;
  logic [QB-1:0]   base;
  logic [SW-1:0]   st;
  logic [QB:0]     dv;
  logic [QB:0]     rem;
  logic [NB-1:0]   qn;

  logic [2*QB:0]   pw_prod;
  logic [2*QB:0]   bs_prod;
  logic [QB:0]     pw_q;
  logic [QB-1:0]   bs_q;
  logic [QB:0]     d_calc;
  logic [QB+1:0]   trial;
  logic [MW-1:0]   qx;
  logic [DATA_WIDTH-1:0] res;

  always_comb begin
    pw_prod = (2*QB+1)'(pw) * (2*QB+1)'(base);
    bs_prod = (2*QB+1)'(base) * (2*QB+1)'(base);
    pw_q    = (QB+1)'((pw_prod + ((2*QB+1)'(1) << (QB-1))) >> QB);
    bs_q    = QB'((bs_prod + ((2*QB+1)'(1) << (QB-1))) >> QB);
    d_calc  = ONE - pw;
    trial   = {rem, qn[NB-1]};
    qx      = MW'(qn);
    if (dv == '0 || qx > MW'({DATA_WIDTH{1'b1}})) begin
      res = {DATA_WIDTH{1'b1}};
    end else begin
      res = DATA_WIDTH'(qn);
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      sel   <= 1'b0;
      cnt   <= '0;
    end else if (req.start) begin
      state <= S_LOAD;
      sel   <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
        end
        S_LOAD: begin
          base  <= sel ? req.beta_second : req.beta_first;
          pw    <= ONE;
          st    <= (req.step_count == '0) ? SW'(1) : req.step_count;
          cnt   <= '0;
          state <= S_POWER;
        end
        S_POWER: begin
          if (st[0]) begin
            pw <= pw_q;
          end
          base <= bs_q;
          st   <= st >> 1;
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(SW-1)) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          dv    <= d_calc;
          rem   <= '0;
          qn    <= (NB'(1) << (QB+FRAC_BITS)) + NB'(d_calc >> 1);
          cnt   <= '0;
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (trial >= {1'b0, dv}) begin
            rem <= (QB+1)'(trial - {1'b0, dv});
            qn  <= {qn[NB-2:0], 1'b1};
          end else begin
            rem <= trial[QB:0];
            qn  <= {qn[NB-2:0], 1'b0};
          end
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NB-1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (sel) begin
            bias2_recip <= res;
            state       <= S_IDLE;
          end else begin
            bias1_recip <= res;
            sel         <= 1'b1;
            state       <= S_LOAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/adam_parameter_update.sv
// ----------------------------------------------------------------------------
// adam_parameter_update
// per-element adam optimizer update, signed fixed point, deep pipeline
// ----------------------------------------------------------------------------
// most of the pipeline is the bit-per-stage square root and the bit-per-stage divider
// throughput: one beat per cycle while bias reciprocals are not updating; a stalled
//   result freezes the whole pipeline
// reset: bias reciprocal sequencing, element ready low until it ends; the same after
//   any write of a beta or step count
`default_nettype none
`include "assert_macros.svh"

module adam_parameter_update #(
  parameter int DATA_WIDTH = adam_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = adam_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  adam_elem_if.sink     elem,
  adam_result_if.source result,
  adam_cfg_if.sink      cfg
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int QB  = adam_pkg::QB;
  localparam int BW  = adam_pkg::BETA_W;
  localparam int UW  = W - 1;
  localparam int SW1 = W + 27;
  localparam int XW  = UW + F;
  localparam int RW  = XW / 2 + 1;
  localparam int SQW = 2 * RW + 1;
  localparam int DW  = ((RW > BW) ? RW : BW) + 1;
  localparam int NW  = W + F;
  localparam int PW  = NW + 2;
  localparam int TD  = 10 + RW;
  localparam int TQ  = TD + NW;
  localparam int TU  = TQ + 1;
  localparam int TP  = TQ + 2;
  localparam int L   = TP + 1;
  localparam logic [BW:0] ONE = (BW+1)'(1) << QB;

  typedef struct packed {
    logic           g_neg;
    logic           m_neg;
    logic [W-1:0]   g_mag;
    logic [W-1:0]   m_mag;
    logic [UW-1:0]  v;
    logic [W-1:0]   p;
    logic           last;
    logic           sat;
    logic [SW1-1:0] s1;
    logic [UW-1:0]  gsq;
    logic [W-1:0]   m1;
    logic [W-1:0]   m1_mag;
    logic           m1_neg;
    logic [UW-1:0]  v1;
    logic           mh_neg;
    logic [W-1:0]   mh_mag;
    logic [UW-1:0]  vhat;
    logic [W-1:0]   num;
    logic [SQW-1:0] sq_rem;
    logic [RW-1:0]  sq_r;
    logic [DW-1:0]  den;
    logic           zden;
    logic [NW-1:0]  dq_n;
    logic [NW-1:0]  dq_q;
    logic [DW-1:0]  dq_r;
    logic [NW:0]    upd;
    logic [W-1:0]   p_new;
  } stage_t;

  // configuration
  logic [BW-1:0]                beta_first, beta_second, epsilon, learning_rate;
  logic [adam_pkg::STEP_W-1:0]  step_count;
  logic                         cfg_start;
  adam_pkg::bias_req_t          bias_req;
  logic [W-1:0]                 bias1, bias2;
  logic                         bias_busy;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_first    <= adam_pkg::BETA_FIRST_RST;
      beta_second   <= adam_pkg::BETA_SECOND_RST;
      epsilon       <= adam_pkg::EPSILON_RST;
      learning_rate <= adam_pkg::LEARNING_RATE_RST;
      step_count    <= adam_pkg::STEP_COUNT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (adam_pkg::cfg_idx_t'(cfg.index))
        adam_pkg::CFG_BETA_FIRST:    beta_first    <= cfg.data;
        adam_pkg::CFG_BETA_SECOND:   beta_second   <= cfg.data;
        adam_pkg::CFG_EPSILON:       epsilon       <= cfg.data;
        adam_pkg::CFG_LEARNING_RATE: learning_rate <= cfg.data;
        adam_pkg::CFG_STEP_COUNT:    step_count    <= cfg.data[adam_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_start = 1'b0;
    if (cfg.valid && cfg.ready) begin
      unique case (adam_pkg::cfg_idx_t'(cfg.index))
        adam_pkg::CFG_BETA_FIRST,
        adam_pkg::CFG_BETA_SECOND,
        adam_pkg::CFG_STEP_COUNT: cfg_start = 1'b1;
        default:                  cfg_start = 1'b0;
      endcase
    end
  end

  assign bias_req = '{beta_first: beta_first, beta_second: beta_second,
                      step_count: step_count, start: cfg_start};

  adam_bias #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_bias (
    .clk         (clk),
    .rst         (rst),
    .req         (bias_req),
    .bias1_recip (bias1),
    .bias2_recip (bias2),
    .busy        (bias_busy)
  );

  // pipeline
  stage_t   pipe [L];
  logic     vld  [L];
  logic     adv;
  stage_t   st0;

  assign adv        = !vld[L-1] || result.ready;
  assign elem.ready = adv && !bias_busy;

  always_comb begin
    st0        = '0;
    st0.g_neg  = elem.gradient[W-1];
    st0.m_neg  = elem.moment1_old[W-1];
    st0.g_mag  = elem.gradient[W-1] ? W'(0) - W'(elem.gradient) : W'(elem.gradient);
    st0.m_mag  = elem.moment1_old[W-1] ? W'(0) - W'(elem.moment1_old)
                                       : W'(elem.moment1_old);
    st0.v      = elem.moment2_old;
    st0.p      = elem.param_old;
    st0.last   = elem.last_in;
    st0.sat    = 1'b0;
  end

  // multipliers
  logic [W+BW-1:0]   p_m1;
  logic [W+BW:0]     p_g1;
  logic [2*W-1:0]    p_gg;
  logic [UW+BW-1:0]  p_v2;
  logic [UW+BW:0]    p_q2;
  logic [2*W-1:0]    p_mh;
  logic [UW+W-1:0]   p_vh;
  logic [BW+W-1:0]   p_lr;

  adam_mul #(.AW(W), .BW(BW)) u_mul_m1 (
    .clk(clk), .en(adv), .a(pipe[0].m_mag), .b(beta_first), .p(p_m1));
  adam_mul #(.AW(W), .BW(BW+1)) u_mul_g1 (
    .clk(clk), .en(adv), .a(pipe[0].g_mag), .b(ONE - (BW+1)'(beta_first)), .p(p_g1));
  adam_mul #(.AW(W), .BW(W)) u_mul_gg (
    .clk(clk), .en(adv), .a(pipe[0].g_mag), .b(pipe[0].g_mag), .p(p_gg));
  adam_mul #(.AW(UW), .BW(BW)) u_mul_v2 (
    .clk(clk), .en(adv), .a(pipe[3].v), .b(beta_second), .p(p_v2));
  adam_mul #(.AW(UW), .BW(BW+1)) u_mul_q2 (
    .clk(clk), .en(adv), .a(pipe[3].gsq), .b(ONE - (BW+1)'(beta_second)), .p(p_q2));
  adam_mul #(.AW(W), .BW(W)) u_mul_mh (
    .clk(clk), .en(adv), .a(pipe[4].m1_mag), .b(bias1), .p(p_mh));
  adam_mul #(.AW(UW), .BW(W)) u_mul_vh (
    .clk(clk), .en(adv), .a(pipe[6].v1), .b(bias2), .p(p_vh));
  adam_mul #(.AW(BW), .BW(W)) u_mul_lr (
    .clk(clk), .en(adv), .a(learning_rate), .b(pipe[7].mh_mag), .p(p_lr));

  // first moment sum and gradient square
  logic [SW1-1:0] s1_n;
  logic [UW-1:0]  gsq_n;
  logic           gsq_sat;

  always_comb begin
    logic [SW1-1:0] a1, a2;
    logic [2*W:0]   gr;
    a1 = SW1'(p_m1);
    a2 = SW1'(p_g1);
    s1_n = (pipe[2].m_neg ? SW1'(0) - a1 : a1) + (pipe[2].g_neg ? SW1'(0) - a2 : a2);
    gr = ((2*W+1)'(p_gg) + ((2*W+1)'(1) << (F-1))) >> F;
    gsq_sat = gr > (2*W+1)'({UW{1'b1}});
    gsq_n = gsq_sat ? {UW{1'b1}} : UW'(gr);
  end

  // first moment round and clamp
  logic [W-1:0] m1_n, m1_mag_n;
  logic         m1_neg_n, m1_sat;

  always_comb begin
    logic [SW1-1:0] mag, rnd, lim;
    m1_neg_n = pipe[3].s1[SW1-1];
    mag = m1_neg_n ? SW1'(0) - pipe[3].s1 : pipe[3].s1;
    rnd = (mag + (SW1'(1) << (QB-1))) >> QB;
    lim = m1_neg_n ? (SW1'(1) << (W-1)) : (SW1'(1) << (W-1)) - SW1'(1);
    m1_sat = rnd > lim;
    m1_mag_n = W'(m1_sat ? lim : rnd);
    m1_n = m1_neg_n ? W'(0) - m1_mag_n : m1_mag_n;
  end

  // second moment
  logic [UW-1:0] v1_n;
  logic          v1_sat;

  always_comb begin
    logic [W+25:0] sum;
    sum = ((W+26)'(p_v2) + (W+26)'(p_q2) + ((W+26)'(1) << (QB-1))) >> QB;
    v1_sat = sum > (W+26)'({UW{1'b1}});
    v1_n = v1_sat ? {UW{1'b1}} : UW'(sum);
  end

  // bias corrected moments
  logic [W-1:0]  mh_mag_n;
  logic          mh_sat;
  logic [UW-1:0] vhat_n;
  logic          vhat_sat;

  always_comb begin
    logic [2*W:0]  rnd, lim;
    logic [UW+W:0] vr;
    rnd = ((2*W+1)'(p_mh) + ((2*W+1)'(1) << (F-1))) >> F;
    lim = pipe[6].m1_neg ? ((2*W+1)'(1) << (W-1)) : ((2*W+1)'(1) << (W-1)) - (2*W+1)'(1);
    mh_sat = rnd > lim;
    mh_mag_n = W'(mh_sat ? lim : rnd);
    vr = ((UW+W+1)'(p_vh) + ((UW+W+1)'(1) << (F-1))) >> F;
    vhat_sat = vr > (UW+W+1)'({UW{1'b1}});
    vhat_n = vhat_sat ? {UW{1'b1}} : UW'(vr);
  end

  // step numerator
  logic [W-1:0] num_n;
  assign num_n = W'(((BW+W+1)'(p_lr) + ((BW+W+1)'(1) << (QB-1))) >> QB);

  // square root, one result bit per stage
  logic [SQW-1:0] sq_t     [RW];
  logic [SQW-1:0] sq_rem_n [RW];
  logic [RW-1:0]  sq_r_n   [RW];

  always_comb begin
    for (int k = 0; k < RW; k++) begin
      sq_t[k] = (SQW'(pipe[9+k].sq_r) << (RW-k)) + (SQW'(1) << (2*(RW-1-k)));
      if (pipe[9+k].sq_rem >= sq_t[k]) begin
        sq_rem_n[k] = pipe[9+k].sq_rem - sq_t[k];
        sq_r_n[k]   = pipe[9+k].sq_r | (RW'(1) << (RW-1-k));
      end else begin
        sq_rem_n[k] = pipe[9+k].sq_rem;
        sq_r_n[k]   = pipe[9+k].sq_r;
      end
    end
  end

  logic [DW-1:0] den_n;
  always_comb begin
    logic inc;
    inc = pipe[TD-1].sq_rem > SQW'(pipe[TD-1].sq_r);
    den_n = DW'(pipe[TD-1].sq_r) + DW'(epsilon) + DW'(inc);
  end

  // divider, one quotient bit per stage
  logic [DW-1:0] dq_r_n [NW];
  logic [NW-1:0] dq_q_n [NW];

  always_comb begin
    for (int j = 0; j < NW; j++) begin
      logic [DW:0] trial;
      trial = {pipe[TD+j].dq_r, pipe[TD+j].dq_n[NW-1-j]};
      if (trial >= {1'b0, pipe[TD+j].den}) begin
        dq_r_n[j] = DW'(trial - {1'b0, pipe[TD+j].den});
        dq_q_n[j] = pipe[TD+j].dq_q | (NW'(1) << (NW-1-j));
      end else begin
        dq_r_n[j] = trial[DW-1:0];
        dq_q_n[j] = pipe[TD+j].dq_q;
      end
    end
  end

  logic [NW:0] upd_n;
  assign upd_n = (NW+1)'(pipe[TQ].dq_q) +
                 (NW+1)'({pipe[TQ].dq_r, 1'b0} >= {1'b0, pipe[TQ].den});

  // parameter step and clamp
  logic [W-1:0] pnew_n;
  logic         p_sat;

  always_comb begin
    logic signed [PW-1:0] ps, updx, pmax, pmin;
    updx = $signed(PW'(pipe[TU].upd));
    pmax = $signed(PW'({1'b0, {(W-1){1'b1}}}));
    pmin = -pmax - PW'(1);
    ps = PW'($signed(pipe[TU].p)) + (pipe[TU].mh_neg ? updx : -updx);
    p_sat = 1'b0;
    if (pipe[TU].zden) begin
      pnew_n = pipe[TU].p;
    end else if (ps > pmax) begin
      pnew_n = W'(pmax);
      p_sat  = 1'b1;
    end else if (ps < pmin) begin
      pnew_n = W'(pmin);
      p_sat  = 1'b1;
    end else begin
      pnew_n = W'(ps);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < L; t++) begin
        vld[t] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= elem.valid && elem.ready;
      for (int t = 1; t < L; t++) begin
        vld[t] <= vld[t-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= st0;
      for (int t = 1; t < L; t++) begin
        pipe[t] <= pipe[t-1];
      end
      pipe[3].s1      <= s1_n;
      pipe[3].gsq     <= gsq_n;
      pipe[3].sat     <= pipe[2].sat | gsq_sat;
      pipe[4].m1      <= m1_n;
      pipe[4].m1_mag  <= m1_mag_n;
      pipe[4].m1_neg  <= m1_neg_n;
      pipe[4].sat     <= pipe[3].sat | m1_sat;
      pipe[6].v1      <= v1_n;
      pipe[6].sat     <= pipe[5].sat | v1_sat;
      pipe[7].mh_mag  <= mh_mag_n;
      pipe[7].mh_neg  <= pipe[6].m1_neg;
      pipe[7].sat     <= pipe[6].sat | mh_sat;
      pipe[9].vhat    <= vhat_n;
      pipe[9].sq_rem  <= SQW'(vhat_n) << F;
      pipe[9].sq_r    <= '0;
      pipe[9].sat     <= pipe[8].sat | vhat_sat;
      pipe[10].num    <= num_n;
      for (int k = 0; k < RW; k++) begin
        pipe[10+k].sq_rem <= sq_rem_n[k];
        pipe[10+k].sq_r   <= sq_r_n[k];
      end
      pipe[TD].den    <= den_n;
      pipe[TD].zden   <= (den_n == '0);
      pipe[TD].dq_n   <= NW'(pipe[TD-1].num) << F;
      pipe[TD].dq_r   <= '0;
      pipe[TD].dq_q   <= '0;
      for (int j = 0; j < NW; j++) begin
        pipe[TD+1+j].dq_r <= dq_r_n[j];
        pipe[TD+1+j].dq_q <= dq_q_n[j];
      end
      pipe[TU].upd    <= upd_n;
      pipe[TP].p_new  <= pnew_n;
      pipe[TP].sat    <= pipe[TU].sat | p_sat;
    end
  end

  assign result.valid       = vld[L-1];
  assign result.moment1_new = pipe[L-1].m1;
  assign result.moment2_new = pipe[L-1].v1;
  assign result.param_new   = pipe[L-1].p_new;
  assign result.last_out    = pipe[L-1].last;
  assign result.saturated   = pipe[L-1].sat;

  // checks
  `ADAM_ASSERT_NEXT(a_beat_enters, clk, rst, elem.valid && elem.ready, vld[0],
                    "accepted beat missing from first stage")
  `ADAM_ASSERT_NEXT(a_stall_holds, clk, rst, !adv, $stable(pipe[L-1].p_new) && vld[L-1],
                    "pipeline moved during stall")
  `ADAM_ASSERT_IMPLY(a_div_rem, clk, rst, vld[TQ] && !pipe[TQ].zden,
                     pipe[TQ].dq_r < pipe[TQ].den, "divider remainder not below divisor")
  `ADAM_ASSERT_IMPLY(a_zero_den, clk, rst, vld[L-1] && pipe[L-1].zden,
                     pipe[L-1].p_new == pipe[L-1].p, "zero denominator moved parameter")
  `ADAM_ASSERT_IMPLY(a_busy_block, clk, rst, bias_busy, !elem.ready,
                     "beat taken while bias reciprocals update")

endmodule

`default_nettype wire
